// ===== rtl/core/mpwa_pkg.sv =====
// shared types, constants and helpers for the max pool window argmax block
// no dependencies

package mpwa_pkg;

   localparam int MAX_IMAGE_WIDTH = 1024;
   localparam int MAX_POOL        = 8;
   localparam int SAMPLE_BITS     = 16;

   localparam int DIM_W   = 11;
   localparam int COL_W   = $clog2(MAX_IMAGE_WIDTH);
   localparam int POOL_W  = 4;
   localparam int OFS_W   = $clog2(MAX_POOL);
   localparam int VALUE_W = SAMPLE_BITS - 1;
   localparam int ARG_W   = 2 * OFS_W + 1;
   localparam int ENTRY_W = VALUE_W + ARG_W;

   localparam int RSP_FIELDS_W = VALUE_W + 2 * COL_W + 2 * OFS_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam int CSR_INDEX_W = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 8'd0,
      CSR_IMAGE_HEIGHT = 8'd1,
      CSR_POOL_WIDTH   = 8'd2,
      CSR_POOL_HEIGHT  = 8'd3
   } csr_index_type;

   localparam logic [DIM_W-1:0]  RESET_IMAGE_DIM = DIM_W'(28);
   localparam logic [POOL_W-1:0] RESET_POOL_DIM  = POOL_W'(2);

   typedef struct packed {
      logic [DIM_W-1:0]  img_w;
      logic [DIM_W-1:0]  img_h;
      logic [POOL_W-1:0] pool_w;
      logic [POOL_W-1:0] pool_h;
   } cfg_type;

   typedef struct packed {
      logic [COL_W-1:0] oc;
      logic [COL_W-1:0] orow;
      logic [OFS_W-1:0] fw;
      logic [OFS_W-1:0] fh;
      logic             in_win;
      logic             first;
      logic             last;
      logic             frame_last;
   } pos_type;

   typedef struct packed {
      logic             positive;
      logic [OFS_W-1:0] row;
      logic [OFS_W-1:0] col;
   } arg_type;

   typedef struct packed {
      arg_type            arg;
      logic [VALUE_W-1:0] max;
   } entry_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_IMAGE_WIDTH)) begin
         r = DIM_W'(MAX_IMAGE_WIDTH);
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [POOL_W-1:0] clamp_pool(input logic [POOL_W-1:0] v);
      logic [POOL_W-1:0] r;
      if (v == '0) begin
         r = POOL_W'(1);
      end else if (v > POOL_W'(MAX_POOL)) begin
         r = POOL_W'(MAX_POOL);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/max_pool_window_argmax.sv =====
// max pooling with winning offset per window, streaming, one sample per cycle unless stalled
// result path: the last sample of a window passes the compare stage register, then the result register
// throughput: one sample per cycle; stalls only while a result waits in the output register
// and the next window result is ready behind it
// reset: position, handshakes and registers to 28x28 image with 2x2 windows; column store
// needs no clearing since each window overwrites its entry on its first sample
// depends on mpwa_pkg, mpwa_pos, mpwa_ram

module max_pool_window_argmax
   import mpwa_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [SAMPLE_BITS-1:0] req_tdata,    // sample
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,    // pooled_value, out_col, out_row, win_row, win_col
   output logic                   rsp_tuser,    // positive_found
   output logic                   rsp_tlast,    // frame_last
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]       csr_data
);

   cfg_type cfg_ff, cfg_in;
   pos_type pos;
   logic    csr_write, accept;

   // config registers
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  cfg_in.img_w  = clamp_dim(csr_data);
            CSR_IMAGE_HEIGHT: cfg_in.img_h  = clamp_dim(csr_data);
            CSR_POOL_WIDTH:   cfg_in.pool_w = clamp_pool(csr_data[POOL_W-1:0]);
            CSR_POOL_HEIGHT:  cfg_in.pool_h = clamp_pool(csr_data[POOL_W-1:0]);
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.img_w  <= RESET_IMAGE_DIM;
         cfg_ff.img_h  <= RESET_IMAGE_DIM;
         cfg_ff.pool_w <= RESET_POOL_DIM;
         cfg_ff.pool_h <= RESET_POOL_DIM;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mpwa_pos u_pos (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .advance (accept),
      .restart (csr_write),
      .pos     (pos)
   );

   // compare stage
   logic                   s1_valid_ff, s1_valid_in;
   pos_type                s1_pos_ff;
   logic [SAMPLE_BITS-1:0] s1_sample_ff;
   logic                   s1_fwd_ff, s1_fwd_in;
   entry_type              s1_fwd_data_ff;
   entry_type              ram_rd_data, base, updated;
   logic                   s1_out, s1_adv, greater;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;
   logic                  rsp_tuser_ff, rsp_tlast_ff;

   mpwa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_IMAGE_WIDTH)
   ) u_column_ram (
      .clock   (clock),
      .wr_en   (s1_adv && s1_pos_ff.in_win),
      .wr_addr (s1_pos_ff.oc),
      .wr_data (updated),
      .rd_en   (accept),
      .rd_addr (pos.oc),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      priority if (s1_pos_ff.first) begin
         base = '0;
      end else if (s1_fwd_ff) begin
         base = s1_fwd_data_ff;
      end else begin
         base = ram_rd_data;
      end
      greater = !s1_sample_ff[SAMPLE_BITS-1] && (s1_sample_ff[VALUE_W-1:0] > base.max);
      updated = base;
      if (greater) begin
         updated.max          = s1_sample_ff[VALUE_W-1:0];
         updated.arg.positive = 1'b1;
         updated.arg.row      = s1_pos_ff.fh;
         updated.arg.col      = s1_pos_ff.fw;
      end
   end

   assign s1_out      = s1_pos_ff.in_win && s1_pos_ff.last;
   assign s1_adv      = s1_valid_ff && (!s1_out || !rsp_valid_ff || rsp_tready);
   assign req_tready  = !s1_valid_ff || s1_adv;
   assign accept      = req_tvalid && req_tready;
   assign s1_valid_in = accept || (s1_valid_ff && !s1_adv);
   // same column written back on the edge the next item reads it
   assign s1_fwd_in   = s1_adv && s1_pos_ff.in_win && (s1_pos_ff.oc == pos.oc);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_fwd_ff   <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (accept) begin
            s1_fwd_ff <= s1_fwd_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pos_ff      <= pos;
         s1_sample_ff   <= req_tdata;
         s1_fwd_data_ff <= updated;
      end
   end

   // result register
   assign rsp_valid_in = (s1_adv && s1_out) || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_out) begin
         rsp_tdata_ff <= RSP_DATA_W'({updated.arg.col, updated.arg.row, s1_pos_ff.orow,
                                      s1_pos_ff.oc, updated.max});
         rsp_tuser_ff <= updated.arg.positive;
         rsp_tlast_ff <= s1_pos_ff.frame_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   ap_fwd_needs_item: assert property (@(posedge clock) disable iff (reset)
      $rose(s1_fwd_ff) |-> s1_valid_ff)
      else $error("forward flag on empty stage");

   ap_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && s1_out && rsp_valid_ff && !rsp_tready)
      else $error("input stalled without a waiting result");

   ap_no_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[VALUE_W-1:0] == '0
         && rsp_tdata[RSP_FIELDS_W-1:VALUE_W+2*COL_W] == '0)
      else $error("window without positive sample has nonzero value or offset");

   ap_restart: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> pos.first && pos.oc == '0 && pos.orow == '0)
      else $error("configuration write did not restart the frame");

   ap_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(s1_valid_ff && s1_out))
      else $error("result without a completed window");

endmodule

// ===== rtl/core/mpwa_ram.sv =====
// generic single write port ram with registered read
// no dependencies

module mpwa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/mpwa_pos.sv =====
// frame and window position tracker: sample position, window offsets, output position
// depends on mpwa_pkg

module mpwa_pos
   import mpwa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    advance,
   input  logic    restart,
   output pos_type pos
);

   logic [COL_W-1:0] col_ff, col_in;
   logic [COL_W-1:0] row_ff, row_in;
   logic [OFS_W-1:0] fw_ff, fw_in;
   logic [OFS_W-1:0] fh_ff, fh_in;
   logic [COL_W-1:0] oc_ff, oc_in;
   logic [COL_W-1:0] orow_ff, orow_in;
   logic [COL_W-1:0] ws_ff, ws_in;
   logic [COL_W-1:0] rs_ff, rs_in;

   logic [DIM_W:0]  ws_end, rs_end, ws_next_end, rs_next_end;
   logic [DIM_W-1:0] col_inc, row_inc;
   logic [POOL_W-1:0] fw_inc, fh_inc;
   logic row_end, frame_end, fw_wrap, fh_wrap;

   always_comb begin
      ws_end      = (DIM_W+1)'(ws_ff) + (DIM_W+1)'(cfg.pool_w);
      rs_end      = (DIM_W+1)'(rs_ff) + (DIM_W+1)'(cfg.pool_h);
      ws_next_end = ws_end + (DIM_W+1)'(cfg.pool_w);
      rs_next_end = rs_end + (DIM_W+1)'(cfg.pool_h);
      col_inc     = DIM_W'(col_ff) + DIM_W'(1);
      row_inc     = DIM_W'(row_ff) + DIM_W'(1);
      fw_inc      = POOL_W'(fw_ff) + POOL_W'(1);
      fh_inc      = POOL_W'(fh_ff) + POOL_W'(1);
      row_end     = col_inc >= cfg.img_w;
      frame_end   = row_inc >= cfg.img_h;
      fw_wrap     = fw_inc >= cfg.pool_w;
      fh_wrap     = fh_inc >= cfg.pool_h;

      pos.oc         = oc_ff;
      pos.orow       = orow_ff;
      pos.fw         = fw_ff;
      pos.fh         = fh_ff;
      pos.in_win     = (ws_end <= (DIM_W+1)'(cfg.img_w)) && (rs_end <= (DIM_W+1)'(cfg.img_h));
      pos.first      = (fw_ff == '0) && (fh_ff == '0);
      pos.last       = fw_wrap && fh_wrap;
      pos.frame_last = (ws_next_end > (DIM_W+1)'(cfg.img_w))
                       && (rs_next_end > (DIM_W+1)'(cfg.img_h));
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      fw_in   = fw_ff;
      fh_in   = fh_ff;
      oc_in   = oc_ff;
      orow_in = orow_ff;
      ws_in   = ws_ff;
      rs_in   = rs_ff;
      priority if (restart) begin
         col_in  = '0;
         row_in  = '0;
         fw_in   = '0;
         fh_in   = '0;
         oc_in   = '0;
         orow_in = '0;
         ws_in   = '0;
         rs_in   = '0;
      end else if (advance) begin
         if (row_end) begin
            col_in = '0;
            fw_in  = '0;
            oc_in  = '0;
            ws_in  = '0;
            if (frame_end) begin
               row_in  = '0;
               fh_in   = '0;
               orow_in = '0;
               rs_in   = '0;
            end else begin
               row_in = row_inc[COL_W-1:0];
               if (fh_wrap) begin
                  fh_in   = '0;
                  orow_in = orow_ff + COL_W'(1);
                  rs_in   = row_inc[COL_W-1:0];
               end else begin
                  fh_in = fh_inc[OFS_W-1:0];
               end
            end
         end else begin
            col_in = col_inc[COL_W-1:0];
            if (fw_wrap) begin
               fw_in = '0;
               oc_in = oc_ff + COL_W'(1);
               ws_in = col_inc[COL_W-1:0];
            end else begin
               fw_in = fw_inc[OFS_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         fw_ff   <= '0;
         fh_ff   <= '0;
         oc_ff   <= '0;
         orow_ff <= '0;
         ws_ff   <= '0;
         rs_ff   <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         fw_ff   <= fw_in;
         fh_ff   <= fh_in;
         oc_ff   <= oc_in;
         orow_ff <= orow_in;
         ws_ff   <= ws_in;
         rs_ff   <= rs_in;
      end
   end

endmodule
